FILE: rtl/thread_table_scheduler_top_assert.svh
// assertion macros for the thread table scheduler
`ifndef THREAD_TABLE_SCHEDULER_TOP_ASSERT_SVH
`define THREAD_TABLE_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("scheduler assertion failed");
`define TTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");
`else
`define TTS_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define TTS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/tts_pkg.sv
// shared types and codes of the thread table scheduler
`default_nettype none
package tts_pkg;
   localparam int MaxThreads = 16;
   localparam int IdxW = 4;
   localparam int LinkW = IdxW + 1;
   localparam logic [LinkW-1:0] LinkNone = {1'b1, {IdxW{1'b0}}};

   // slot states
   localparam logic [2:0] StFree    = 3'd0;
   localparam logic [2:0] StRunning = 3'd1;
   localparam logic [2:0] StReady   = 3'd2;
   localparam logic [2:0] StExited  = 3'd3;
   localparam logic [2:0] StWaiting = 3'd4;
   localparam logic [2:0] StKilled  = 3'd5;

   // commands
   localparam logic [2:0] ModeCreate = 3'd0;
   localparam logic [2:0] ModeYield  = 3'd1;
   localparam logic [2:0] ModeExit   = 3'd2;
   localparam logic [2:0] ModeKill   = 3'd3;
   localparam logic [2:0] ModeWait   = 3'd4;

   // yield targets
   localparam logic [1:0] KindId   = 2'd0;
   localparam logic [1:0] KindAny  = 2'd1;
   localparam logic [1:0] KindSelf = 2'd2;

   // result status
   localparam logic [1:0] StatOk      = 2'd0;
   localparam logic [1:0] StatInvalid = 2'd1;
   localparam logic [1:0] StatNoReady = 2'd2;
   localparam logic [1:0] StatNoFree  = 2'd3;

   typedef struct packed {
      logic [IdxW-1:0]  rd_addr;
      logic             ss_we;
      logic [IdxW-1:0]  ss_addr;
      logic [2:0]       ss_data;
      logic             nl_we;
      logic [IdxW-1:0]  nl_addr;
      logic [LinkW-1:0] nl_data;
      logic             jh_we;
      logic             jt_we;
      logic [IdxW-1:0]  j_addr;
      logic [LinkW-1:0] jh_data;
      logic [LinkW-1:0] jt_data;
      logic             rh_we;
      logic [LinkW-1:0] rh_data;
      logic             rt_we;
      logic [LinkW-1:0] rt_data;
      logic             cur_we;
      logic [IdxW-1:0]  cur_data;
      logic             halt_set;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0]       ss_rd;
      logic [LinkW-1:0] nl_rd;
      logic [LinkW-1:0] jh_rd;
      logic [LinkW-1:0] jt_rd;
      logic [LinkW-1:0] ready_head;
      logic [LinkW-1:0] ready_tail;
      logic [IdxW-1:0]  current;
      logic             halt;
   } dp_stat_type;
endpackage
`default_nettype wire

FILE: rtl/tts_datapath.sv
// thread table, link arrays and list heads of the scheduler
`default_nettype none
module tts_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tts_pkg::dp_cmd_type  cmd,
   output tts_pkg::dp_stat_type      stat
);
   logic [2:0]                 ss_ff [tts_pkg::MaxThreads];
   logic [tts_pkg::LinkW-1:0]  nl_ff [tts_pkg::MaxThreads];
   logic [tts_pkg::LinkW-1:0]  jh_ff [tts_pkg::MaxThreads];
   logic [tts_pkg::LinkW-1:0]  jt_ff [tts_pkg::MaxThreads];
   logic [tts_pkg::LinkW-1:0]  rh_ff;
   logic [tts_pkg::LinkW-1:0]  rt_ff;
   logic [tts_pkg::IdxW-1:0]   cur_ff;
   logic                       halt_ff;

   // single read port over the tables
   always_comb begin
      stat.ss_rd      = ss_ff[cmd.rd_addr];
      stat.nl_rd      = nl_ff[cmd.rd_addr];
      stat.jh_rd      = jh_ff[cmd.rd_addr];
      stat.jt_rd      = jt_ff[cmd.rd_addr];
      stat.ready_head = rh_ff;
      stat.ready_tail = rt_ff;
      stat.current    = cur_ff;
      stat.halt       = halt_ff;
   end

   // table writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tts_pkg::MaxThreads; i++) begin
            ss_ff[i] <= (i == 0) ? tts_pkg::StRunning : tts_pkg::StFree;
            nl_ff[i] <= tts_pkg::LinkNone;
            jh_ff[i] <= tts_pkg::LinkNone;
            jt_ff[i] <= tts_pkg::LinkNone;
         end
         rh_ff   <= tts_pkg::LinkNone;
         rt_ff   <= tts_pkg::LinkNone;
         cur_ff  <= '0;
         halt_ff <= 1'b0;
      end else begin
         if (cmd.ss_we) ss_ff[cmd.ss_addr] <= cmd.ss_data;
         if (cmd.nl_we) nl_ff[cmd.nl_addr] <= cmd.nl_data;
         if (cmd.jh_we) jh_ff[cmd.j_addr] <= cmd.jh_data;
         if (cmd.jt_we) jt_ff[cmd.j_addr] <= cmd.jt_data;
         if (cmd.rh_we) rh_ff <= cmd.rh_data;
         if (cmd.rt_we) rt_ff <= cmd.rt_data;
         if (cmd.cur_we) cur_ff <= cmd.cur_data;
         if (cmd.halt_set) halt_ff <= 1'b1;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/tts_ctrl.sv
// command sequencer of the scheduler: list walks, reaping and result register
`default_nettype none
module tts_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [2:0]                    in_mode,
   input  wire logic [1:0]                    in_kind,
   input  wire logic [tts_pkg::IdxW-1:0]      in_tid,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [1:0]                         out_status,
   output logic [tts_pkg::IdxW-1:0]           out_rid,
   output logic [tts_pkg::IdxW-1:0]           out_running,
   output logic [tts_pkg::LinkW-1:0]          out_woken,
   output logic                               out_halted,
   output tts_pkg::dp_cmd_type                cmd,
   input  wire tts_pkg::dp_stat_type          stat
);
   localparam int IW = tts_pkg::IdxW;
   localparam int LW = tts_pkg::LinkW;
   localparam logic [LW-1:0] LastIdx = LW'(tts_pkg::MaxThreads - 1);
   localparam logic [LW-1:0] Count   = LW'(tts_pkg::MaxThreads);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_REAP   = 5'd1;
   localparam logic [4:0] S_CREATE = 5'd2;
   localparam logic [4:0] S_YIELD  = 5'd3;
   localparam logic [4:0] S_YT1    = 5'd4;
   localparam logic [4:0] S_YT2    = 5'd5;
   localparam logic [4:0] S_YT3    = 5'd6;
   localparam logic [4:0] S_EXIT   = 5'd7;
   localparam logic [4:0] S_KILL   = 5'd8;
   localparam logic [4:0] S_KILL2  = 5'd9;
   localparam logic [4:0] S_WAIT   = 5'd10;
   localparam logic [4:0] S_WAIT2  = 5'd11;
   localparam logic [4:0] S_RH     = 5'd12;
   localparam logic [4:0] S_RH2    = 5'd13;
   localparam logic [4:0] S_PUSH1  = 5'd14;
   localparam logic [4:0] S_PUSH2  = 5'd15;
   localparam logic [4:0] S_RM     = 5'd16;
   localparam logic [4:0] S_RM2    = 5'd17;
   localparam logic [4:0] S_WK0    = 5'd18;
   localparam logic [4:0] S_WK1    = 5'd19;
   localparam logic [4:0] S_FINISH = 5'd20;

   logic [4:0]    state_ff, state_in;
   logic [2:0]    mode_ff, mode_in;
   logic [1:0]    kind_ff, kind_in;
   logic [IW-1:0] tid_ff, tid_in;
   logic [IW-1:0] me_ff, me_in;
   logic [LW-1:0] i_ff, i_in;
   logic [1:0]    status_ff, status_in;
   logic [IW-1:0] rid_ff, rid_in;
   logic [LW-1:0] woken_ff, woken_in;
   logic [IW-1:0] push_t_ff, push_t_in;
   logic [4:0]    push_ret_ff, push_ret_in;
   logic [IW-1:0] rm_t_ff, rm_t_in;
   logic [4:0]    rm_ret_ff, rm_ret_in;
   logic [LW-1:0] rm_cur_ff, rm_cur_in;
   logic [LW-1:0] rm_prev_ff, rm_prev_in;
   logic [LW-1:0] rm_n_ff, rm_n_in;
   logic [IW-1:0] wk_t_ff, wk_t_in;
   logic [4:0]    wk_ret_ff, wk_ret_in;
   logic [LW-1:0] wk_cur_ff, wk_cur_in;
   logic [IW-1:0] rh_t_ff, rh_t_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [IW-1:0] rsp_rid_ff, rsp_rid_in;
   logic [IW-1:0] rsp_run_ff, rsp_run_in;
   logic [LW-1:0] rsp_woken_ff, rsp_woken_in;
   logic          rsp_halt_ff, rsp_halt_in;
   logic          head_none;

   assign head_none   = stat.ready_head[IW];
   assign in_ready    = (state_ff == S_IDLE);
   assign out_valid   = rsp_valid_ff;
   assign out_status  = rsp_status_ff;
   assign out_rid     = rsp_rid_ff;
   assign out_running = rsp_run_ff;
   assign out_woken   = rsp_woken_ff;
   assign out_halted  = rsp_halt_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;     mode_in = mode_ff;       kind_in = kind_ff;
      tid_in = tid_ff;         me_in = me_ff;           i_in = i_ff;
      status_in = status_ff;   rid_in = rid_ff;         woken_in = woken_ff;
      push_t_in = push_t_ff;   push_ret_in = push_ret_ff;
      rm_t_in = rm_t_ff;       rm_ret_in = rm_ret_ff;   rm_cur_in = rm_cur_ff;
      rm_prev_in = rm_prev_ff; rm_n_in = rm_n_ff;
      wk_t_in = wk_t_ff;       wk_ret_in = wk_ret_ff;   wk_cur_in = wk_cur_ff;
      rh_t_in = rh_t_ff;
      rsp_valid_in = rsp_valid_ff;     rsp_status_in = rsp_status_ff;
      rsp_rid_in = rsp_rid_ff;         rsp_run_in = rsp_run_ff;
      rsp_woken_in = rsp_woken_ff;     rsp_halt_in = rsp_halt_ff;
      cmd = '0;
      if (rsp_valid_ff && out_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               mode_in = in_mode;
               kind_in = in_kind;
               tid_in = in_tid;
               me_in = stat.current;
               i_in = '0;
               status_in = tts_pkg::StatOk;
               rid_in = '0;
               woken_in = '0;
               if (stat.halt) begin
                  status_in = tts_pkg::StatNoReady;
                  state_in = S_FINISH;
               end else begin
                  case (in_mode)
                     tts_pkg::ModeCreate, tts_pkg::ModeYield: state_in = S_REAP;
                     tts_pkg::ModeExit: begin
                        wk_t_in = stat.current;
                        wk_ret_in = S_EXIT;
                        state_in = S_WK0;
                     end
                     tts_pkg::ModeKill: state_in = S_KILL;
                     tts_pkg::ModeWait: state_in = S_WAIT;
                     default: begin
                        status_in = tts_pkg::StatInvalid;
                        state_in = S_FINISH;
                     end
                  endcase
               end
            end
         end
         // free every exited slot, one slot a cycle
         S_REAP: begin
            cmd.rd_addr = i_ff[IW-1:0];
            if (stat.ss_rd == tts_pkg::StExited) begin
               cmd.ss_we = 1'b1;  cmd.ss_addr = i_ff[IW-1:0];
               cmd.ss_data = tts_pkg::StFree;
               cmd.nl_we = 1'b1;  cmd.nl_addr = i_ff[IW-1:0];
               cmd.nl_data = tts_pkg::LinkNone;
               cmd.jh_we = 1'b1;  cmd.jt_we = 1'b1;
               cmd.j_addr = i_ff[IW-1:0];
               cmd.jh_data = tts_pkg::LinkNone;
               cmd.jt_data = tts_pkg::LinkNone;
            end
            if (i_ff == LastIdx) begin
               i_in = '0;
               state_in = (mode_ff == tts_pkg::ModeCreate) ? S_CREATE : S_YIELD;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         // lowest free slot search
         S_CREATE: begin
            cmd.rd_addr = i_ff[IW-1:0];
            if (stat.ss_rd == tts_pkg::StFree) begin
               cmd.ss_we = 1'b1;  cmd.ss_addr = i_ff[IW-1:0];
               cmd.ss_data = tts_pkg::StReady;
               cmd.jh_we = 1'b1;  cmd.jt_we = 1'b1;
               cmd.j_addr = i_ff[IW-1:0];
               cmd.jh_data = tts_pkg::LinkNone;
               cmd.jt_data = tts_pkg::LinkNone;
               rid_in = i_ff[IW-1:0];
               push_t_in = i_ff[IW-1:0];
               push_ret_in = S_FINISH;
               state_in = S_PUSH1;
            end else if (i_ff == LastIdx) begin
               status_in = tts_pkg::StatNoFree;
               state_in = S_FINISH;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_YIELD: begin
            cmd.rd_addr = tid_ff;
            case (kind_ff)
               tts_pkg::KindAny: begin
                  if (head_none) begin
                     status_in = tts_pkg::StatNoReady;
                     state_in = S_FINISH;
                  end else begin
                     rid_in = stat.ready_head[IW-1:0];
                     tid_in = stat.ready_head[IW-1:0];
                     state_in = S_YT1;
                  end
               end
               tts_pkg::KindSelf: begin
                  rid_in = me_ff;
                  state_in = S_FINISH;
               end
               tts_pkg::KindId: begin
                  rid_in = tid_ff;
                  if (stat.ss_rd != tts_pkg::StReady && stat.ss_rd != tts_pkg::StRunning) begin
                     status_in = tts_pkg::StatInvalid;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_YT1;
                  end
               end
               default: begin
                  status_in = tts_pkg::StatInvalid;
                  state_in = S_FINISH;
               end
            endcase
         end
         // switch to a ready thread
         S_YT1: begin
            if (tid_ff == me_ff) begin
               state_in = S_FINISH;
            end else begin
               cmd.ss_we = 1'b1;  cmd.ss_addr = me_ff;
               cmd.ss_data = tts_pkg::StReady;
               push_t_in = me_ff;
               push_ret_in = S_YT2;
               state_in = S_PUSH1;
            end
         end
         S_YT2: begin
            rm_t_in = tid_ff;
            rm_ret_in = S_YT3;
            rm_cur_in = stat.ready_head;
            rm_prev_in = tts_pkg::LinkNone;
            rm_n_in = '0;
            state_in = S_RM;
         end
         S_YT3: begin
            cmd.ss_we = 1'b1;  cmd.ss_addr = tid_ff;
            cmd.ss_data = tts_pkg::StRunning;
            cmd.cur_we = 1'b1; cmd.cur_data = tid_ff;
            state_in = S_FINISH;
         end
         // exit after joiners are released
         S_EXIT: begin
            cmd.ss_we = 1'b1;  cmd.ss_addr = me_ff;
            cmd.ss_data = tts_pkg::StExited;
            if (head_none) begin
               cmd.halt_set = 1'b1;
               status_in = tts_pkg::StatNoReady;
               rid_in = me_ff;
               state_in = S_FINISH;
            end else begin
               rid_in = stat.ready_head[IW-1:0];
               state_in = S_RH;
            end
         end
         S_KILL: begin
            cmd.rd_addr = tid_ff;
            rid_in = tid_ff;
            wk_t_in = tid_ff;
            wk_ret_in = S_FINISH;
            if (stat.ss_rd == tts_pkg::StFree || stat.ss_rd == tts_pkg::StExited ||
                stat.ss_rd == tts_pkg::StKilled || tid_ff == me_ff) begin
               status_in = tts_pkg::StatInvalid;
               state_in = S_FINISH;
            end else if (stat.ss_rd == tts_pkg::StReady) begin
               rm_t_in = tid_ff;
               rm_ret_in = S_KILL2;
               rm_cur_in = stat.ready_head;
               rm_prev_in = tts_pkg::LinkNone;
               rm_n_in = '0;
               state_in = S_RM;
            end else begin
               cmd.ss_we = 1'b1;  cmd.ss_addr = tid_ff;
               cmd.ss_data = (stat.ss_rd == tts_pkg::StWaiting) ?
                             tts_pkg::StKilled : tts_pkg::StExited;
               state_in = S_WK0;
            end
         end
         S_KILL2: begin
            cmd.ss_we = 1'b1;  cmd.ss_addr = tid_ff;
            cmd.ss_data = tts_pkg::StExited;
            state_in = S_WK0;
         end
         S_WAIT: begin
            cmd.rd_addr = tid_ff;
            rid_in = tid_ff;
            if (tid_ff == me_ff || stat.ss_rd == tts_pkg::StFree ||
                stat.ss_rd == tts_pkg::StExited || stat.ss_rd == tts_pkg::StKilled) begin
               status_in = tts_pkg::StatInvalid;
               state_in = S_FINISH;
            end else if (head_none) begin
               status_in = tts_pkg::StatNoReady;
               state_in = S_FINISH;
            end else begin
               cmd.ss_we = 1'b1;  cmd.ss_addr = me_ff;
               cmd.ss_data = tts_pkg::StWaiting;
               cmd.nl_we = 1'b1;  cmd.nl_addr = me_ff;
               cmd.nl_data = tts_pkg::LinkNone;
               state_in = S_WAIT2;
            end
         end
         // append running thread to the target's join list
         S_WAIT2: begin
            cmd.rd_addr = tid_ff;
            cmd.j_addr = tid_ff;
            cmd.jh_data = {1'b0, me_ff};
            cmd.jt_data = {1'b0, me_ff};
            cmd.jt_we = 1'b1;
            if (stat.jh_rd[IW]) begin
               cmd.jh_we = 1'b1;
            end else if (!stat.jt_rd[IW]) begin
               cmd.nl_we = 1'b1;
               cmd.nl_addr = stat.jt_rd[IW-1:0];
               cmd.nl_data = {1'b0, me_ff};
            end
            state_in = S_RH;
         end
         // ready head runs
         S_RH: begin
            rh_t_in = stat.ready_head[IW-1:0];
            rm_t_in = stat.ready_head[IW-1:0];
            rm_ret_in = S_RH2;
            rm_cur_in = stat.ready_head;
            rm_prev_in = tts_pkg::LinkNone;
            rm_n_in = '0;
            state_in = S_RM;
         end
         S_RH2: begin
            cmd.ss_we = 1'b1;  cmd.ss_addr = rh_t_ff;
            cmd.ss_data = tts_pkg::StRunning;
            cmd.cur_we = 1'b1; cmd.cur_data = rh_t_ff;
            state_in = S_FINISH;
         end
         // append to the ready tail
         S_PUSH1: begin
            if (head_none) begin
               cmd.rh_we = 1'b1;  cmd.rh_data = {1'b0, push_t_ff};
               cmd.rt_we = 1'b1;  cmd.rt_data = {1'b0, push_t_ff};
               cmd.nl_we = 1'b1;  cmd.nl_addr = push_t_ff;
               cmd.nl_data = tts_pkg::LinkNone;
               state_in = push_ret_ff;
            end else begin
               if (!stat.ready_tail[IW]) begin
                  cmd.nl_we = 1'b1;
                  cmd.nl_addr = stat.ready_tail[IW-1:0];
                  cmd.nl_data = {1'b0, push_t_ff};
               end
               state_in = S_PUSH2;
            end
         end
         S_PUSH2: begin
            cmd.nl_we = 1'b1;  cmd.nl_addr = push_t_ff;
            cmd.nl_data = tts_pkg::LinkNone;
            cmd.rt_we = 1'b1;  cmd.rt_data = {1'b0, push_t_ff};
            state_in = push_ret_ff;
         end
         // walk the ready list and unlink one thread
         S_RM: begin
            cmd.rd_addr = rm_cur_ff[IW-1:0];
            if (rm_cur_ff[IW] || rm_n_ff == Count) begin
               state_in = rm_ret_ff;
            end else if (rm_cur_ff[IW-1:0] == rm_t_ff) begin
               if (rm_prev_ff[IW]) begin
                  cmd.rh_we = 1'b1;  cmd.rh_data = stat.nl_rd;
               end else begin
                  cmd.nl_we = 1'b1;  cmd.nl_addr = rm_prev_ff[IW-1:0];
                  cmd.nl_data = stat.nl_rd;
               end
               if (stat.ready_tail == rm_cur_ff) begin
                  cmd.rt_we = 1'b1;  cmd.rt_data = rm_prev_ff;
               end
               state_in = S_RM2;
            end else begin
               rm_prev_in = rm_cur_ff;
               rm_cur_in = stat.nl_rd;
               rm_n_in = rm_n_ff + 1'b1;
            end
         end
         S_RM2: begin
            cmd.nl_we = 1'b1;  cmd.nl_addr = rm_cur_ff[IW-1:0];
            cmd.nl_data = tts_pkg::LinkNone;
            state_in = rm_ret_ff;
         end
         // release joiners in list order
         S_WK0: begin
            cmd.rd_addr = wk_t_ff;
            wk_cur_in = stat.jh_rd;
            state_in = S_WK1;
         end
         S_WK1: begin
            cmd.rd_addr = wk_cur_ff[IW-1:0];
            if (wk_cur_ff[IW] || woken_ff == Count) begin
               cmd.jh_we = 1'b1;  cmd.jt_we = 1'b1;
               cmd.j_addr = wk_t_ff;
               cmd.jh_data = tts_pkg::LinkNone;
               cmd.jt_data = tts_pkg::LinkNone;
               state_in = wk_ret_ff;
            end else begin
               cmd.nl_we = 1'b1;  cmd.nl_addr = wk_cur_ff[IW-1:0];
               cmd.nl_data = tts_pkg::LinkNone;
               cmd.ss_we = 1'b1;  cmd.ss_addr = wk_cur_ff[IW-1:0];
               wk_cur_in = stat.nl_rd;
               woken_in = woken_ff + 1'b1;
               if (stat.ss_rd == tts_pkg::StKilled) begin
                  cmd.ss_data = tts_pkg::StExited;
               end else begin
                  cmd.ss_data = tts_pkg::StReady;
                  push_t_in = wk_cur_ff[IW-1:0];
                  push_ret_in = S_WK1;
                  state_in = S_PUSH1;
               end
            end
         end
         // load the result register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || out_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_rid_in = rid_ff;
               rsp_run_in = stat.current;
               rsp_woken_in = woken_ff;
               rsp_halt_in = stat.halt;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;       kind_ff <= kind_in;       tid_ff <= tid_in;
      me_ff <= me_in;           i_ff <= i_in;             status_ff <= status_in;
      rid_ff <= rid_in;         woken_ff <= woken_in;
      push_t_ff <= push_t_in;   push_ret_ff <= push_ret_in;
      rm_t_ff <= rm_t_in;       rm_ret_ff <= rm_ret_in;   rm_cur_ff <= rm_cur_in;
      rm_prev_ff <= rm_prev_in; rm_n_ff <= rm_n_in;
      wk_t_ff <= wk_t_in;       wk_ret_ff <= wk_ret_in;   wk_cur_ff <= wk_cur_in;
      rh_t_ff <= rh_t_in;
      rsp_status_ff <= rsp_status_in;  rsp_rid_ff <= rsp_rid_in;
      rsp_run_ff <= rsp_run_in;        rsp_woken_ff <= rsp_woken_in;
      rsp_halt_ff <= rsp_halt_in;
   end
endmodule
`default_nettype wire

FILE: rtl/thread_table_scheduler_top.sv
// top level of the thread table scheduler
// throughput: one command at a time, the next accepted once the result register is loaded
// create and yield first run a reap scan over every slot; the time to result valid for exit, kill
// and wait is set by the list walks; a halted scheduler goes straight to the result
// a result still waiting at the output holds the sequencer in its last state
// reset: synchronous; slot zero running, all other slots free, lists empty, not halted
`default_nettype none
`include "thread_table_scheduler_top_assert.svh"
module thread_table_scheduler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // mode[2:0], target_id[6:3], zero[7]
   input  wire logic [1:0]  req_tuser,   // target_kind[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // status[1:0], result_id[5:2], running_id[9:6],
                                         // woken_count[14:10], halted[15]
);
   tts_pkg::dp_cmd_type  cmd;
   tts_pkg::dp_stat_type stat;
   logic [1:0]                   out_status;
   logic [tts_pkg::IdxW-1:0]     out_rid;
   logic [tts_pkg::IdxW-1:0]     out_running;
   logic [tts_pkg::LinkW-1:0]    out_woken;
   logic                         out_halted;

   tts_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_mode     (req_tdata[2:0]),
      .in_kind     (req_tuser),
      .in_tid      (req_tdata[6:3]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_status  (out_status),
      .out_rid     (out_rid),
      .out_running (out_running),
      .out_woken   (out_woken),
      .out_halted  (out_halted),
      .cmd         (cmd),
      .stat        (stat)
   );

   tts_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // result packing
   assign rsp_tdata = {out_halted, out_woken, out_running, out_rid, out_status};

   // checks
   `TTS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `TTS_ASSERT_NEXT(a_halt_sticky, clock, reset, stat.halt, stat.halt)
   `TTS_ASSERT_ALWAYS(a_halted_status, clock, reset,
                      !(rsp_tvalid && out_halted) || out_status == tts_pkg::StatNoReady)
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for the thread table scheduler
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NoLink = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   // fields from the highest bit down, matching the rsp_tdata packing
   typedef struct packed {
      logic       halted;
      logic [4:0] woken_count;
      logic [3:0] running_id;
      logic [3:0] result_id;
      logic [1:0] status;
   } sched_result_type;

   // predictor state
   logic [2:0] slot_st [tts_pkg::MaxThreads];
   int         link_nx [tts_pkg::MaxThreads];
   int         jhead [tts_pkg::MaxThreads];
   int         jtail [tts_pkg::MaxThreads];
   int         rhead, rtail, cur_thr;
   bit         halted_q;

   sched_result_type pending_results[$];
   int  error_count = 0;
   int  burst_left = 0;
   bit  hold_off = 1'b0;
   bit  idle_en = 1'b1;

   thread_table_scheduler_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor: list helpers
   function automatic void ready_append(int t);
      link_nx[t] = NoLink;
      if (rhead == NoLink) rhead = t;
      else link_nx[rtail] = t;
      rtail = t;
   endfunction

   function automatic void ready_unlink(int t);
      int prv, c;
      prv = NoLink;
      c = rhead;
      for (int n = 0; n < tts_pkg::MaxThreads && c != NoLink; n++) begin
         if (c == t) begin
            if (prv == NoLink) rhead = link_nx[c];
            else link_nx[prv] = link_nx[c];
            if (rtail == c) rtail = prv;
            link_nx[c] = NoLink;
            return;
         end
         prv = c;
         c = link_nx[c];
      end
   endfunction

   function automatic int release_joiners(int t);
      int cnt, c, nx;
      cnt = 0;
      c = jhead[t];
      for (int n = 0; n < tts_pkg::MaxThreads && c != NoLink; n++) begin
         nx = link_nx[c];
         link_nx[c] = NoLink;
         if (slot_st[c] == tts_pkg::StKilled) slot_st[c] = tts_pkg::StExited;
         else begin
            slot_st[c] = tts_pkg::StReady;
            ready_append(c);
         end
         cnt++;
         c = nx;
      end
      jhead[t] = NoLink;
      jtail[t] = NoLink;
      return cnt;
   endfunction

   function automatic void reap_exited();
      for (int i = 0; i < tts_pkg::MaxThreads; i++)
         if (slot_st[i] == tts_pkg::StExited) begin
            slot_st[i] = tts_pkg::StFree;
            link_nx[i] = NoLink;
            jhead[i] = NoLink;
            jtail[i] = NoLink;
         end
   endfunction

   function automatic void switch_to(int t);
      if (t == cur_thr) return;
      slot_st[cur_thr] = tts_pkg::StReady;
      ready_append(cur_thr);
      ready_unlink(t);
      slot_st[t] = tts_pkg::StRunning;
      cur_thr = t;
   endfunction

   function automatic int run_ready_head();
      int t;
      t = rhead;
      ready_unlink(t);
      slot_st[t] = tts_pkg::StRunning;
      cur_thr = t;
      return t;
   endfunction

   function automatic void sched_reset();
      for (int i = 0; i < tts_pkg::MaxThreads; i++) begin
         slot_st[i] = tts_pkg::StFree;
         link_nx[i] = NoLink;
         jhead[i] = NoLink;
         jtail[i] = NoLink;
      end
      slot_st[0] = tts_pkg::StRunning;
      rhead = NoLink;
      rtail = NoLink;
      cur_thr = 0;
      halted_q = 1'b0;
   endfunction

   // work out the result of one command and update the predictor
   function automatic sched_result_type schedule_cmd(logic [2:0] mode, logic [1:0] kind,
                                                     logic [3:0] tid);
      sched_result_type r;
      int me;
      r = '0;
      me = cur_thr;
      if (halted_q) r.status = tts_pkg::StatNoReady;
      else case (mode)
         tts_pkg::ModeCreate: begin
            reap_exited();
            r.status = tts_pkg::StatNoFree;
            for (int i = 0; i < tts_pkg::MaxThreads; i++)
               if (slot_st[i] == tts_pkg::StFree) begin
                  slot_st[i] = tts_pkg::StReady;
                  jhead[i] = NoLink;
                  jtail[i] = NoLink;
                  ready_append(i);
                  r.result_id = 4'(i);
                  r.status = tts_pkg::StatOk;
                  break;
               end
         end
         tts_pkg::ModeYield: begin
            reap_exited();
            if (kind == tts_pkg::KindAny) begin
               if (rhead == NoLink) r.status = tts_pkg::StatNoReady;
               else begin
                  r.result_id = 4'(rhead);
                  switch_to(rhead);
               end
            end else if (kind == tts_pkg::KindSelf) begin
               r.result_id = 4'(me);
            end else if (kind == tts_pkg::KindId) begin
               r.result_id = tid;
               if (slot_st[tid] != tts_pkg::StReady && slot_st[tid] != tts_pkg::StRunning)
                  r.status = tts_pkg::StatInvalid;
               else switch_to(tid);
            end else r.status = tts_pkg::StatInvalid;
         end
         tts_pkg::ModeExit: begin
            r.woken_count = 5'(release_joiners(me));
            slot_st[me] = tts_pkg::StExited;
            if (rhead == NoLink) begin
               halted_q = 1'b1;
               r.status = tts_pkg::StatNoReady;
               r.result_id = 4'(me);
            end else r.result_id = 4'(run_ready_head());
         end
         tts_pkg::ModeKill: begin
            r.result_id = tid;
            if (slot_st[tid] == tts_pkg::StFree || slot_st[tid] == tts_pkg::StExited ||
                slot_st[tid] == tts_pkg::StKilled || tid == me)
               r.status = tts_pkg::StatInvalid;
            else begin
               if (slot_st[tid] == tts_pkg::StReady) begin
                  ready_unlink(tid);
                  slot_st[tid] = tts_pkg::StExited;
               end else if (slot_st[tid] == tts_pkg::StWaiting) begin
                  slot_st[tid] = tts_pkg::StKilled;
               end else slot_st[tid] = tts_pkg::StExited;
               r.woken_count = 5'(release_joiners(tid));
            end
         end
         tts_pkg::ModeWait: begin
            r.result_id = tid;
            if (tid == me || slot_st[tid] == tts_pkg::StFree ||
                slot_st[tid] == tts_pkg::StExited || slot_st[tid] == tts_pkg::StKilled)
               r.status = tts_pkg::StatInvalid;
            else if (rhead == NoLink) r.status = tts_pkg::StatNoReady;
            else begin
               slot_st[me] = tts_pkg::StWaiting;
               link_nx[me] = NoLink;
               if (jhead[tid] == NoLink) jhead[tid] = me;
               else link_nx[jtail[tid]] = me;
               jtail[tid] = me;
               void'(run_ready_head());
            end
         end
         default: r.status = tts_pkg::StatInvalid;
      endcase
      r.running_id = 4'(cur_thr);
      r.halted = halted_q;
      return r;
   endfunction

   // send one command transaction; bursts of random length, with random gaps between them when idle_en is set
   task automatic send_cmd(logic [2:0] mode, logic [1:0] kind, logic [3:0] tid);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         if (idle_en) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, tid, mode};
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(schedule_cmd(mode, kind, tid));
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else if (!idle_en) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // result checker
   always @(posedge clock) begin
      sched_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
               error_count++;
            end
            if (got.result_id !== want.result_id) begin
               $display("%0t: result_id exp %0d got %0d", $time, want.result_id,
                        got.result_id);
               error_count++;
            end
            if (got.running_id !== want.running_id) begin
               $display("%0t: running_id exp %0d got %0d", $time, want.running_id,
                        got.running_id);
               error_count++;
            end
            if (got.woken_count !== want.woken_count) begin
               $display("%0t: woken_count exp %0d got %0d", $time, want.woken_count,
                        got.woken_count);
               error_count++;
            end
            if (got.halted !== want.halted) begin
               $display("%0t: halted exp %0d got %0d", $time, want.halted, got.halted);
               error_count++;
            end
         end
      end
   end

   // directed: table full, yields of every kind, joins, kills, exit, invalid modes
   task automatic test_directed();
      for (int i = 0; i < 16; i++) send_cmd(tts_pkg::ModeCreate, 2'd0, 4'd0);
      send_cmd(tts_pkg::ModeYield, tts_pkg::KindSelf, 4'd0);
      send_cmd(tts_pkg::ModeYield, tts_pkg::KindAny, 4'd0);
      send_cmd(tts_pkg::ModeYield, tts_pkg::KindId, 4'd15);
      send_cmd(tts_pkg::ModeYield, 2'd3, 4'd5);
      send_cmd(tts_pkg::ModeWait, 2'd0, 4'd15);
      send_cmd(tts_pkg::ModeWait, 2'd3, 4'd15);
      send_cmd(tts_pkg::ModeKill, 2'd0, 4'd15);
      send_cmd(tts_pkg::ModeExit, 2'd0, 4'd0);
      send_cmd(tts_pkg::ModeKill, 2'd0, 4'd2);
      send_cmd(3'd7, 2'd0, 4'd0);
      send_cmd(3'd5, 2'd0, 4'd9);
   endtask

   // receiver holds off while commands keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 10; i++) send_cmd(tts_pkg::ModeYield, tts_pkg::KindAny, 4'd0);
      join
   endtask

   // random command mix biased towards well-formed traffic
   task automatic test_random(int count);
      logic [2:0] m;
      int sel;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) idle_en = ($urandom_range(0, 2) != 0);
         sel = $urandom_range(0, 99);
         if (sel < 25) m = tts_pkg::ModeCreate;
         else if (sel < 50) m = tts_pkg::ModeYield;
         else if (sel < 60) m = tts_pkg::ModeExit;
         else if (sel < 75) m = tts_pkg::ModeKill;
         else if (sel < 95) m = tts_pkg::ModeWait;
         else m = 3'($urandom_range(0, 7));
         send_cmd(m, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
      end
      idle_en = 1'b1;
   endtask

   // exit until halted, then check that further commands are answered with no-ready status
   task automatic test_halt();
      int guard;
      guard = 0;
      while (!halted_q && guard < 200) begin
         send_cmd(tts_pkg::ModeExit, 2'd0, 4'd0);
         guard++;
      end
      send_cmd(tts_pkg::ModeCreate, 2'd0, 4'd0);
      send_cmd(tts_pkg::ModeYield, tts_pkg::KindAny, 4'd0);
   endtask

   initial begin
      sched_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random(420);
      test_halt();
      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("** thread_table_scheduler_top: PASSED **");
      else
         $display("** thread_table_scheduler_top: FAILED **");
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("** thread_table_scheduler_top: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
